// File: src/periodic_task_heap_scheduler_defines.svh
// Assertion macros for the periodic task heap scheduler checker.
`ifndef PERIODIC_TASK_HEAP_SCHEDULER_DEFINES_SVH
`define PERIODIC_TASK_HEAP_SCHEDULER_DEFINES_SVH

// Same-cycle implication, gated by reset.
`define PTHS_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, gated by reset.
`define PTHS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/pths_pkg.sv
// ----------------------------------------------------------------------------
// pths_pkg
// Shared constants, types and the heap ordering function.
// ----------------------------------------------------------------------------
package pths_pkg;

    localparam int MAX_TASKS    = 16;
    localparam int MAX_DISPATCH = 64;
    localparam int IDX_W  = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W  = $clog2(MAX_TASKS + 1);
    localparam int DISP_W = $clog2(MAX_DISPATCH + 1);

    localparam logic       MODE_ADD  = 1'b0;
    localparam logic       MODE_TICK = 1'b1;
    localparam logic [1:0] KIND_ADD  = 2'd0;
    localparam logic [1:0] KIND_DISP = 2'd1;
    localparam logic [1:0] KIND_IDLE = 2'd2;

    typedef struct packed {
        logic [7:0]         handler;
        logic [31:0]        interval;
        logic [31:0]        due;
        logic signed [15:0] prio;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic tick_start;
        logic load_add;
        logic up_rd;
        logic up_cmp;
        logic chk_rd;
        logic chk_take;
        logic last_rd;
        logic dn_load;
        logic dn_rd;
        logic dn_cmp;
        logic push_item;
        logic emit_pend;
        logic emit_add;
        logic emit_idle;
        logic emit_last;
        logic emit_acc;
    } t_cmd;

    typedef struct packed {
        logic add_ok;
        logic x_zero;
        logic up_stop;
        logic due_ok;
        logic cnt_one;
        logic dn_stop;
        logic pend_valid;
    } t_stat;

    // Earlier due time first, lower priority on a tie.
    function automatic logic goes_before(input t_entry a, input t_entry b);
        if (a.due != b.due) begin
            return a.due < b.due;
        end
        return a.prio < b.prio;
    endfunction

endpackage

// File: src/pths_ram.sv
// ----------------------------------------------------------------------------
// pths_ram
// Generic RAM, one write port, two registered read ports.
// ----------------------------------------------------------------------------
module pths_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr0,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr1,
    output logic [WIDTH-1:0]                           o_rdata0,
    output logic [WIDTH-1:0]                           o_rdata1
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata0 <= r_mem[i_raddr0];
        o_rdata1 <= r_mem[i_raddr1];
    end
endmodule

// File: src/pths_dpath.sv
// ----------------------------------------------------------------------------
// pths_dpath
// Heap storage, sift registers, counters and result registers.
// ----------------------------------------------------------------------------
module pths_dpath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  pths_pkg::t_cmd       i_cmd,
    output pths_pkg::t_stat      o_stat,
    input  logic [7:0]           i_task_handler,
    input  logic [31:0]          i_interval,
    input  logic signed [15:0]   i_priority_req,
    input  logic [31:0]          i_current_time,
    output logic                 o_strobe,
    output logic [1:0]           o_kind,
    output logic                 o_accepted,
    output logic [7:0]           o_dispatched_handler,
    output logic [31:0]          o_was_due_at,
    output logic                 o_last
);
    import pths_pkg::*;

    t_entry            r_v, r_item;
    logic [IDX_W-1:0]  r_x;
    logic [CNT_W-1:0]  r_cnt;
    logic [DISP_W-1:0] r_n;
    logic [31:0]       r_now;
    logic [7:0]        r_pend_h;
    logic [31:0]       r_pend_due;
    logic              r_pend_v;

    logic [ENTRY_W-1:0] rdata0, rdata1, wdata;
    logic [IDX_W-1:0]   raddr0, waddr, par;
    logic [IDX_W+1:0]   lw, rw;
    logic               we;
    t_entry             e0, e1, best, child;
    logic               l_in, r_in, sel_l, sel_r;

    assign e0  = t_entry'(rdata0);
    assign e1  = t_entry'(rdata1);
    assign par = (r_x - IDX_W'(1)) >> 1;
    assign lw  = {1'b0, r_x, 1'b1};
    assign rw  = {1'b0, r_x, 1'b0} + (IDX_W+2)'(2);
    assign l_in  = lw < (IDX_W+2)'(r_cnt);
    assign r_in  = rw < (IDX_W+2)'(r_cnt);
    assign sel_l = l_in && goes_before(e0, r_v);
    assign best  = sel_l ? e0 : r_v;
    assign sel_r = r_in && goes_before(e1, best);
    assign child = sel_r ? e1 : e0;

    assign o_stat.add_ok     = (r_cnt < CNT_W'(MAX_TASKS)) && (i_task_handler != 8'd0);
    assign o_stat.x_zero     = (r_x == '0);
    assign o_stat.up_stop    = !goes_before(r_v, e0);
    assign o_stat.due_ok     = (r_cnt != '0) && (r_now >= e0.due)
                               && (r_n < DISP_W'(MAX_DISPATCH));
    assign o_stat.cnt_one    = (r_cnt == CNT_W'(1));
    assign o_stat.dn_stop    = !sel_l && !sel_r;
    assign o_stat.pend_valid = r_pend_v;

    always_comb begin
        raddr0 = '0;
        if (i_cmd.up_rd) begin
            raddr0 = par;
        end else if (i_cmd.last_rd) begin
            raddr0 = r_cnt[IDX_W-1:0];
        end else if (i_cmd.dn_rd) begin
            raddr0 = lw[IDX_W-1:0];
        end
        we    = 1'b0;
        waddr = r_x;
        wdata = r_v;
        if (i_cmd.up_rd && o_stat.x_zero) begin
            we = 1'b1;
        end else if (i_cmd.up_cmp) begin
            we = 1'b1;
            if (!o_stat.up_stop) begin
                wdata = e0;
            end
        end else if (i_cmd.dn_cmp) begin
            we = 1'b1;
            if (!o_stat.dn_stop) begin
                wdata = child;
            end
        end
    end

    pths_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_TASKS)) u_ram (
        .i_clk    (i_clk),
        .i_we     (we),
        .i_waddr  (waddr),
        .i_wdata  (wdata),
        .i_raddr0 (raddr0),
        .i_raddr1 (rw[IDX_W-1:0]),
        .o_rdata0 (rdata0),
        .o_rdata1 (rdata1)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_pend_v <= 1'b0;
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= i_cmd.emit_pend || i_cmd.emit_add || i_cmd.emit_idle;
            if (i_cmd.tick_start) begin
                r_now    <= i_current_time;
                r_n      <= '0;
                r_pend_v <= 1'b0;
            end
            if (i_cmd.load_add) begin
                r_v   <= '{handler: i_task_handler, interval: i_interval,
                           due: 32'd0, prio: i_priority_req};
                r_x   <= r_cnt[IDX_W-1:0];
                r_cnt <= r_cnt + CNT_W'(1);
            end
            if (i_cmd.push_item) begin
                r_v   <= r_item;
                r_x   <= r_cnt[IDX_W-1:0];
                r_cnt <= r_cnt + CNT_W'(1);
            end
            if (i_cmd.up_cmp && !o_stat.up_stop) begin
                r_x <= par;
            end
            if (i_cmd.chk_take) begin
                r_pend_h   <= e0.handler;
                r_pend_due <= e0.due;
                r_pend_v   <= 1'b1;
                r_item     <= '{handler: e0.handler, interval: e0.interval,
                                due: e0.due + e0.interval, prio: e0.prio};
                r_n        <= r_n + DISP_W'(1);
                r_cnt      <= r_cnt - CNT_W'(1);
            end
            if (i_cmd.dn_load) begin
                r_v <= e0;
                r_x <= '0;
            end
            if (i_cmd.dn_cmp && !o_stat.dn_stop) begin
                r_x <= sel_r ? rw[IDX_W-1:0] : lw[IDX_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_pend) begin
            o_kind               <= KIND_DISP;
            o_accepted           <= 1'b0;
            o_dispatched_handler <= r_pend_h;
            o_was_due_at         <= r_pend_due;
            o_last               <= i_cmd.emit_last;
        end else if (i_cmd.emit_add || i_cmd.emit_idle) begin
            o_kind               <= i_cmd.emit_add ? KIND_ADD : KIND_IDLE;
            o_accepted           <= i_cmd.emit_add && i_cmd.emit_acc;
            o_dispatched_handler <= 8'd0;
            o_was_due_at         <= 32'd0;
            o_last               <= 1'b1;
        end
    end
endmodule

// File: src/pths_ctrl.sv
// ----------------------------------------------------------------------------
// pths_ctrl
// Sequencer for insert, tick check, extract and reinsert.
// ----------------------------------------------------------------------------
module pths_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  logic            i_mode,
    input  pths_pkg::t_stat i_stat,
    output pths_pkg::t_cmd  o_cmd,
    output logic            busy
);
    import pths_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_UP_RD   = 4'd1;
    localparam logic [3:0] S_UP_CMP  = 4'd2;
    localparam logic [3:0] S_CHK_RD  = 4'd3;
    localparam logic [3:0] S_CHK     = 4'd4;
    localparam logic [3:0] S_LAST_RD = 4'd5;
    localparam logic [3:0] S_DN_LD   = 4'd6;
    localparam logic [3:0] S_DN_RD   = 4'd7;
    localparam logic [3:0] S_DN_CMP  = 4'd8;
    localparam logic [3:0] S_PUSH    = 4'd9;

    logic [3:0] r_state, n_state;
    logic       r_tick, n_tick;

    assign busy = (r_state != S_IDLE);

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_tick  = r_tick;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_mode == MODE_TICK) begin
                        o_cmd.tick_start = 1'b1;
                        n_tick  = 1'b1;
                        n_state = S_CHK_RD;
                    end else begin
                        n_tick = 1'b0;
                        if (i_stat.add_ok) begin
                            o_cmd.load_add = 1'b1;
                            n_state = S_UP_RD;
                        end else begin
                            o_cmd.emit_add = 1'b1;
                        end
                    end
                end
            end
            S_UP_RD, S_UP_CMP: begin
                o_cmd.up_rd  = (r_state == S_UP_RD);
                o_cmd.up_cmp = (r_state == S_UP_CMP);
                if ((r_state == S_UP_RD) ? i_stat.x_zero : i_stat.up_stop) begin
                    if (r_tick) begin
                        n_state = S_CHK_RD;
                    end else begin
                        o_cmd.emit_add = 1'b1;
                        o_cmd.emit_acc = 1'b1;
                        n_state = S_IDLE;
                    end
                end else begin
                    n_state = (r_state == S_UP_RD) ? S_UP_CMP : S_UP_RD;
                end
            end
            S_CHK_RD: begin
                o_cmd.chk_rd = 1'b1;
                n_state = S_CHK;
            end
            S_CHK: begin
                if (i_stat.due_ok) begin
                    o_cmd.chk_take  = 1'b1;
                    o_cmd.emit_pend = i_stat.pend_valid;
                    n_state = i_stat.cnt_one ? S_PUSH : S_LAST_RD;
                end else begin
                    o_cmd.emit_pend = i_stat.pend_valid;
                    o_cmd.emit_last = 1'b1;
                    o_cmd.emit_idle = !i_stat.pend_valid;
                    n_state = S_IDLE;
                end
            end
            S_LAST_RD: begin
                o_cmd.last_rd = 1'b1;
                n_state = S_DN_LD;
            end
            S_DN_LD: begin
                o_cmd.dn_load = 1'b1;
                n_state = S_DN_RD;
            end
            S_DN_RD: begin
                o_cmd.dn_rd = 1'b1;
                n_state = S_DN_CMP;
            end
            S_DN_CMP: begin
                o_cmd.dn_cmp = 1'b1;
                n_state = i_stat.dn_stop ? S_PUSH : S_DN_RD;
            end
            S_PUSH: begin
                o_cmd.push_item = 1'b1;
                n_state = S_UP_RD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_tick  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_tick  <= n_tick;
        end
    end
endmodule

// File: src/periodic_task_heap_scheduler.sv
// ----------------------------------------------------------------------------
// periodic_task_heap_scheduler
// Periodic task scheduler on a binary min-heap kept in a two-read-port RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Drive the item fields and pulse start while busy is low; the item is
//   taken at that edge. An add (mode 0) stores a task with due time 0; a tick
//   (mode 1) dispatches due tasks in heap order, lowest due time first and
//   lower priority on a tie, up to MAX_DISPATCH per tick.
//   Every result shows on the o_ ports for one cycle with o_strobe high and
//   o_last marks the final result of an item. The receiver cannot stall.
// Sequence:
//   A rejected add answers in the cycle after start. An accepted add sifts up
//   one heap level at a time (parent read, then compare and write). Each tick
//   dispatch does a root check (read, then compare), reads the last entry into
//   the root, sifts it down a level at a time (child read, then compare and write)
//   and sifts the reinserted task up; the single RAM write port paces each step.
// Reset:
//   Synchronous, active low; empties the heap, the RAM contents need no
//   clearing since only entries below the fill count are ever used.
// ----------------------------------------------------------------------------
module periodic_task_heap_scheduler (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_mode,
    input  logic [7:0]         i_task_handler,
    input  logic [31:0]        i_interval,
    input  logic signed [15:0] i_priority_req,
    input  logic [31:0]        i_current_time,
    output logic               o_strobe,
    output logic [1:0]         o_kind,
    output logic               o_accepted,
    output logic [7:0]         o_dispatched_handler,
    output logic [31:0]        o_was_due_at,
    output logic               o_last
);
    import pths_pkg::*;

    // Command and status between the sequencer and the heap datapath.
    t_cmd  cmd;
    t_stat stat;

    pths_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_mode  (i_mode),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .busy    (busy)
    );

    pths_dpath u_dpath (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (cmd),
        .o_stat               (stat),
        .i_task_handler       (i_task_handler),
        .i_interval           (i_interval),
        .i_priority_req       (i_priority_req),
        .i_current_time       (i_current_time),
        .o_strobe             (o_strobe),
        .o_kind               (o_kind),
        .o_accepted           (o_accepted),
        .o_dispatched_handler (o_dispatched_handler),
        .o_was_due_at         (o_was_due_at),
        .o_last               (o_last)
    );
endmodule

// File: src/pths_checker.sv
// ----------------------------------------------------------------------------
// pths_checker
// Port-level checks on the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
`include "periodic_task_heap_scheduler_defines.svh"

module pths_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               i_mode,
    input logic [7:0]         i_task_handler,
    input logic               o_strobe,
    input logic [1:0]         o_kind,
    input logic               o_accepted,
    input logic [7:0]         o_dispatched_handler,
    input logic               o_last
);
    import pths_pkg::*;

    `PTHS_ASSERT_NEXT(a_tick_busy, i_clk, i_rst_n, start && !busy && i_mode == MODE_TICK, busy, "tick not started")
    `PTHS_ASSERT_NEXT(a_null_reject, i_clk, i_rst_n, start && !busy && i_mode == MODE_ADD && i_task_handler == 8'd0, o_strobe && o_kind == KIND_ADD && !o_accepted && o_last, "null add not rejected")
    `PTHS_ASSERT_NOW(a_single_last, i_clk, i_rst_n, o_strobe && o_kind != KIND_DISP, o_last && o_dispatched_handler == 8'd0, "bad single result")
    `PTHS_ASSERT_NOW(a_mid_busy, i_clk, i_rst_n, o_strobe && o_kind == KIND_DISP && !o_last, busy, "idle mid tick")
endmodule

bind periodic_task_heap_scheduler pths_checker u_pths_checker (.*);

// File: tb/sv/periodic_task_heap_scheduler_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_task_heap_scheduler_tb
// Self-checking bench for the heap scheduler: a behavioral heap predicts every
// add answer, dispatch and idle result, and a scoreboard class compares each
// strobed result against the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module periodic_task_heap_scheduler_tb;
    import pths_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    // One predicted or observed result.
    typedef struct packed {
        logic [1:0]  kind;
        logic        accepted;
        logic [7:0]  handler;
        logic [31:0] due_at;
        logic        last;
    } t_result;

    int fail_count = 0;

    // Print one mismatch line and count it.
    task automatic report(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        fail_count++;
    endtask

    // Behavioral heap: tracks the block's task store and predicts results.
    class heap_scoreboard;
        t_entry  tasks[MAX_TASKS];
        int      fill;
        t_result pending[$];

        function void clear();
            fill = 0;
            pending.delete();
        endfunction

        function bit earlier(input int a, input int b);
            if (tasks[a].due != tasks[b].due) return tasks[a].due < tasks[b].due;
            return tasks[a].prio < tasks[b].prio;
        endfunction

        function void swap(input int a, input int b);
            t_entry t;
            t = tasks[a]; tasks[a] = tasks[b]; tasks[b] = t;
        endfunction

        function void insert(input t_entry e);
            int x;
            x = fill;
            tasks[x] = e;
            fill++;
            while (x != 0 && earlier(x, (x - 1) / 2)) begin
                swap(x, (x - 1) / 2);
                x = (x - 1) / 2;
            end
        endfunction

        function void remove_root();
            int x, l, r, m;
            x = 0;
            fill--;
            if (fill == 0) return;
            tasks[0] = tasks[fill];
            forever begin
                l = 2 * x + 1; r = 2 * x + 2; m = x;
                if (l < fill && earlier(l, m)) m = l;
                if (r < fill && earlier(r, m)) m = r;
                if (m == x) break;
                swap(x, m);
                x = m;
            end
        endfunction

        // Note an accepted item and queue what it must produce.
        function void note_item(input logic mode, input logic [7:0] hnd,
                                input logic [31:0] ivl, input logic signed [15:0] pri,
                                input logic [31:0] now);
            t_entry  e;
            t_result r;
            int      n;
            bit      ok;
            if (mode == MODE_ADD) begin
                ok = (fill < MAX_TASKS) && (hnd != 8'd0);
                if (ok) begin
                    e.handler = hnd; e.interval = ivl; e.due = 32'd0; e.prio = pri;
                    insert(e);
                end
                r = '{KIND_ADD, ok, 8'd0, 32'd0, 1'b1};
                pending.push_back(r);
                return;
            end
            n = 0;
            while (n < MAX_DISPATCH && fill > 0 && now >= tasks[0].due) begin
                e = tasks[0];
                remove_root();
                r = '{KIND_DISP, 1'b0, e.handler, e.due, 1'b0};
                pending.push_back(r);
                n++;
                e.due = e.due + e.interval;
                insert(e);
            end
            if (n == 0) begin
                r = '{KIND_IDLE, 1'b0, 8'd0, 32'd0, 1'b1};
                pending.push_back(r);
            end else begin
                pending[pending.size() - 1].last = 1'b1;
            end
        endfunction

        // Compare one strobed result with the oldest prediction.
        task check_result(input t_result got);
            t_result w;
            if (pending.size() == 0) begin
                report($sformatf("unexpected result kind=%0d", got.kind));
                return;
            end
            w = pending.pop_front();
            if (got.kind != w.kind)
                report($sformatf("kind %0d, want %0d", got.kind, w.kind));
            if (got.accepted != w.accepted)
                report($sformatf("accepted %0d, want %0d", got.accepted, w.accepted));
            if (got.handler != w.handler)
                report($sformatf("handler %0d, want %0d", got.handler, w.handler));
            if (got.due_at != w.due_at)
                report($sformatf("was_due_at %0d, want %0d", got.due_at, w.due_at));
            if (got.last != w.last)
                report($sformatf("last %0d, want %0d", got.last, w.last));
        endtask
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic               i_mode = MODE_ADD;
    logic [7:0]         i_task_handler = '0;
    logic [31:0]        i_interval = '0;
    logic signed [15:0] i_priority_req = '0;
    logic [31:0]        i_current_time = '0;
    logic               o_strobe;
    logic [1:0]         o_kind;
    logic               o_accepted;
    logic [7:0]         o_dispatched_handler;
    logic [31:0]        o_was_due_at;
    logic               o_last;

    periodic_task_heap_scheduler dut (.*);

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    heap_scoreboard sched = new();
    int  idle_cycles = 0;
    bit  quiet_stretch = 1'b0;
    logic [31:0] clock_now = 32'd0;

    // Sample results and the handshake at each edge; count stalled cycles.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_strobe)
                sched.check_result('{o_kind, o_accepted, o_dispatched_handler,
                                     o_was_due_at, o_last});
            if ((start && !busy) || o_strobe) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL periodic_task_heap_scheduler");
                $finish;
            end
        end
    end

    // Present one item and hold start until taken; then drop it when idling at random
    // or while busy, else keep it high (the next item then follows without a gap).
    task automatic send_item(input logic mode, input logic [7:0] hnd,
                             input logic [31:0] ivl, input logic signed [15:0] pri,
                             input logic [31:0] now);
        start          <= 1'b1;
        i_mode         <= mode;
        i_task_handler <= hnd;
        i_interval     <= ivl;
        i_priority_req <= pri;
        i_current_time <= now;
        do @(posedge i_clk); while (busy);
        sched.note_item(mode, hnd, ivl, pri, now);
        if (!quiet_stretch && $urandom_range(99) < 7) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end else if (busy !== 1'b0) begin
            start <= 1'b0;
        end
    endtask

    task automatic add_task(input logic [7:0] hnd, input logic [31:0] ivl,
                            input logic signed [15:0] pri);
        send_item(MODE_ADD, hnd, ivl, pri, $urandom);
    endtask

    task automatic tick(input logic [31:0] now);
        send_item(MODE_TICK, 8'($urandom), $urandom, 16'($urandom), now);
    endtask

    // Let every expected result drain, then rest to clear the pipeline.
    task automatic drain();
        start <= 1'b0;
        while (sched.pending.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    initial begin
        int k;
        sched.clear();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: tick on an empty heap, null handler, zero interval bound,
        // ties broken on priority, fill to full and one add beyond it.
        tick(32'd0);
        tick(32'hFFFF_FFFF);
        add_task(8'd0, 32'd5, 16'sd0);
        add_task(8'd7, 32'd0, 16'sd3);
        tick(32'd0);                      // zero interval hits the dispatch limit
        add_task(8'd255, 32'hFFFF_FFFF, -16'sd32768);
        add_task(8'd9, 32'd10, 16'sd32767);
        add_task(8'd1, 32'd1, -16'sd1);
        for (k = 0; k < 13; k++) add_task(8'(10 + k), 32'(100 * k + 3), 16'(k - 6));
        tick(32'd1);
        tick(32'hFFFF_FFFF);              // due times wrap past 2^32
        tick(32'd0);
        drain();

        // Random: adds to the full heap and ticks at nearby times, with a quiet stretch.
        for (k = 0; k < 430; k++) begin
            quiet_stretch = (k >= 150 && k < 230);
            if (k % 90 == 89) begin
                // rebuild from an emptied heap is impossible; re-seed times
                clock_now = $urandom_range(1) ? $urandom : 32'd0;
            end
            if ($urandom_range(99) < 40) begin
                add_task($urandom_range(99) < 8 ? 8'd0 : 8'($urandom),
                         $urandom_range(99) < 10 ? $urandom : 32'($urandom_range(0, 60)),
                         16'($urandom));
            end else begin
                if ($urandom_range(99) < 5) clock_now = $urandom;
                else clock_now = clock_now + $urandom_range(0, 40);
                tick(clock_now);
            end
        end
        drain();

        if (fail_count == 0) begin
            $display("PASS periodic_task_heap_scheduler");
        end else begin
            $display("FAIL periodic_task_heap_scheduler");
        end
        $finish;
    end
endmodule
